// ----- hw/rtl/imu_oc_pkg.sv -----
// Shared types and constants of the IMU offset calibration and correction block.
package imu_oc_pkg;

  localparam int unsigned NumAxes  = 6;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned GravW    = 15;
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AccelZLane = 2;

  localparam logic [CfgIdxW-1:0] CfgSampleCount  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGravityCount = CfgIdxW'(1);

  localparam logic [CntW-1:0]  SampleCountRst = CntW'(100);
  localparam logic [GravW-1:0] GravityRst     = GravW'(16384);

  localparam logic KindCalib   = 1'b0;
  localparam logic KindCorrect = 1'b1;

  typedef struct packed {
    logic acc;
    logic start;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

// ----- hw/rtl/imu_oc_div.sv -----
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module imu_oc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [imu_oc_pkg::SumW-1:0]     dividend_i,
  input  logic [imu_oc_pkg::CntW-1:0]     divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [imu_oc_pkg::AxisW-1:0]    quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [imu_oc_pkg::StepW-1:0]    cnt_q, cnt_d;
  logic [imu_oc_pkg::CntW-1:0]     rem_q, rem_d;
  logic [imu_oc_pkg::SumW-1:0]     quo_q, quo_d;
  logic [imu_oc_pkg::CntW-1:0]     dvs_q, dvs_d;
  logic                            neg_q, neg_d;
  logic [imu_oc_pkg::CntW:0]       shifted;
  logic [imu_oc_pkg::CntW:0]       diff;
  logic                            fits;
  logic [imu_oc_pkg::SumW-1:0]     mag;

  always_comb begin
    shifted = {rem_q, quo_q[imu_oc_pkg::SumW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    mag     = dividend_i[imu_oc_pkg::SumW-1] ? (~dividend_i + imu_oc_pkg::SumW'(1))
                                             : dividend_i;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = mag;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[imu_oc_pkg::SumW-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[imu_oc_pkg::CntW-1:0] : shifted[imu_oc_pkg::CntW-1:0];
      quo_d = {quo_q[imu_oc_pkg::SumW-2:0], fits};
      cnt_d = cnt_q + imu_oc_pkg::StepW'(1);
      if (cnt_q == imu_oc_pkg::StepW'(imu_oc_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q[imu_oc_pkg::AxisW-1:0] + imu_oc_pkg::AxisW'(1))
                        : quo_q[imu_oc_pkg::AxisW-1:0];

endmodule

// ----- hw/rtl/imu_oc_lane.sv -----
// One axis lane: running sum, averaging divider, stored offset and correction subtract.
module imu_oc_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  imu_oc_pkg::lane_ctrl_t          ctrl_i,
  input  logic [imu_oc_pkg::AxisW-1:0]    raw_i,
  input  logic [imu_oc_pkg::CntW-1:0]     count_i,
  input  logic [imu_oc_pkg::GravW-1:0]    gravity_i,
  output imu_oc_pkg::lane_stat_t          stat_o,
  output logic [imu_oc_pkg::AxisW-1:0]    corr_o
);

  logic [imu_oc_pkg::SumW-1:0]  sum_q, sum_d;
  logic [imu_oc_pkg::SumW-1:0]  sum_add;
  logic [imu_oc_pkg::SumW-1:0]  ext;
  logic [imu_oc_pkg::AxisW-1:0] off_q, off_d;
  logic [imu_oc_pkg::AxisW-1:0] quot;
  logic                         div_busy;
  logic                         div_done;

  always_comb begin
    ext     = {{(imu_oc_pkg::SumW - imu_oc_pkg::AxisW){raw_i[imu_oc_pkg::AxisW-1]}}, raw_i};
    sum_add = ctrl_i.acc ? (sum_q + ext) : sum_q;
    sum_d   = ctrl_i.start ? '0 : sum_add;
    off_d   = div_done ? (quot - imu_oc_pkg::AxisW'(gravity_i)) : off_q;
  end

  imu_oc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.start),
    .dividend_i (sum_add),
    .divisor_i  (count_i),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      off_q <= '0;
    end else begin
      sum_q <= sum_d;
      off_q <= off_d;
    end
  end

  assign stat_o.busy = div_busy;
  assign stat_o.done = div_done;
  assign corr_o      = raw_i - off_q;

endmodule

// ----- hw/rtl/imu_offset_calibrate_correct.sv -----
// Top level of the IMU offset calibration and correction block with six axis lanes.
//
//  Channel     Direction  Signals                                  Payload
//  s_axis      in         s_axis_tvalid/tready/tdata/tuser         six raw axes, kind, sample_ok
//  m_axis      out        m_axis_tvalid/tready/tdata/tuser         six corrected axes, valid flag
//  cfg         in         cfg_valid_i/cfg_ready_o/cfg_index_i/data register index and value
//
// A correction request, or a calibration request that does not end a run, leaves the block idle.
// The request that ends a run is accumulated first, then runs the 32-step per-lane divider,
// and the new offsets are committed when the dividers are done.
// Reset clears sums, counter, offsets and the valid flag; no clearing pass is needed.
// Input is stalled while the dividers run and while an unread result is held.
module imu_offset_calibrate_correct (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z,
  // [63:48] gyro_x, [79:64] gyro_y, [95:80] gyro_z
  input  logic [95:0]                         s_axis_tdata,
  // [0] kind, [1] sample_ok
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] corrected_accel_x, [31:16] corrected_accel_y, [47:32] corrected_accel_z,
  // [63:48] corrected_gyro_x, [79:64] corrected_gyro_y, [95:80] corrected_gyro_z
  output logic [95:0]                         m_axis_tdata,
  // [0] offsets_valid
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imu_oc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [imu_oc_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StDiv  = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  logic [imu_oc_pkg::CntW-1:0]     sample_count_q, sample_count_d;
  logic [imu_oc_pkg::GravW-1:0]    gravity_q, gravity_d;
  logic [imu_oc_pkg::CntW-1:0]     seen_q, seen_d;
  logic                            flag_q, flag_d;
  logic                            out_valid_q, out_valid_d;
  logic [95:0]                     out_data_q, out_data_d;
  logic                            out_flag_q, out_flag_d;
  logic [imu_oc_pkg::CntW-1:0]     count;
  logic [imu_oc_pkg::CntW-1:0]     target;
  logic                            run_end;
  logic                            in_acc;
  logic                            cfg_acc;
  logic                            is_calib;
  imu_oc_pkg::lane_ctrl_t          lane_ctrl;
  imu_oc_pkg::lane_stat_t          lane_stat [imu_oc_pkg::NumAxes];
  logic [imu_oc_pkg::AxisW-1:0]    lane_corr [imu_oc_pkg::NumAxes];
  logic [95:0]                     corr_packed;

  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign is_calib      = (s_axis_tuser[0] == imu_oc_pkg::KindCalib);

  always_comb begin
    count   = seen_q + imu_oc_pkg::CntW'(1);
    target  = (sample_count_q == '0) ? imu_oc_pkg::CntW'(1) : sample_count_q;
    run_end = (count >= target);
    lane_ctrl.acc   = in_acc && is_calib && s_axis_tuser[1];
    lane_ctrl.start = in_acc && is_calib && run_end;
  end

  for (genvar g = 0; g < imu_oc_pkg::NumAxes; g++) begin : g_lane
    imu_oc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .raw_i     (s_axis_tdata[g*imu_oc_pkg::AxisW +: imu_oc_pkg::AxisW]),
      .count_i   (count),
      .gravity_i ((g == imu_oc_pkg::AccelZLane) ? gravity_q : '0),
      .stat_o    (lane_stat[g]),
      .corr_o    (lane_corr[g])
    );
    assign corr_packed[g*imu_oc_pkg::AxisW +: imu_oc_pkg::AxisW] = lane_corr[g];
  end

  always_comb begin
    state_d        = state_q;
    sample_count_d = sample_count_q;
    gravity_d      = gravity_q;
    seen_d         = seen_q;
    flag_d         = flag_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    out_flag_d     = out_flag_q;

    if (cfg_acc) begin
      unique case (cfg_index_i)
        imu_oc_pkg::CfgSampleCount:  sample_count_d = cfg_data_i;
        imu_oc_pkg::CfgGravityCount: gravity_d = cfg_data_i[imu_oc_pkg::GravW-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (is_calib) begin
            if (run_end) begin
              seen_d  = '0;
              state_d = StDiv;
            end else begin
              seen_d = count;
            end
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = corr_packed;
            out_flag_d  = flag_q;
          end
        end
      end
      StDiv: begin
        if (lane_stat[0].done) begin
          flag_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      sample_count_q <= imu_oc_pkg::SampleCountRst;
      gravity_q      <= imu_oc_pkg::GravityRst;
      seen_q         <= '0;
      flag_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      sample_count_q <= sample_count_d;
      gravity_q      <= gravity_d;
      seen_q         <= seen_d;
      flag_q         <= flag_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_flag_q <= out_flag_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flag_q;

  a_no_input_while_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> !s_axis_tready)
    else $error("input accepted while the dividers run");

  a_lanes_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_stat[0].done == lane_stat[5].done) && (lane_stat[0].busy == lane_stat[2].busy))
    else $error("axis lanes out of step");

  a_start_enters_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.start |=> (state_q == StDiv) && lane_stat[0].busy)
    else $error("run end did not start the divide");

  a_done_sets_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDiv) && lane_stat[0].done) |=> flag_q && (state_q == StIdle))
    else $error("finished divide did not mark offsets valid");

  a_seen_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != '1)
    else $error("sample counter reached its maximum");

endmodule

// ----- verif/imu_offset_calibrate_correct_checker.sv -----
// Checker that predicts the corrected IMU samples and compares them with the block's output.
module imu_offset_calibrate_correct_checker
  import imu_oc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [95:0]         m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatch_cnt_o,
  output int unsigned         awaited_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NumAxes*AxisW-1:0] axes;
    logic                     calibrated;
  } corrected_t;

  corrected_t      corrected_q[$];
  logic [SumW-1:0] axis_sum [NumAxes];
  logic [AxisW-1:0] axis_bias [NumAxes];
  logic [CntW-1:0] seen_cnt;
  logic            calibrated;
  logic [CntW-1:0] run_len;
  logic [GravW-1:0] gravity;
  string           axis_label [NumAxes] = '{"accel_x", "accel_y", "accel_z",
                                             "gyro_x", "gyro_y", "gyro_z"};
  int unsigned     mismatches = 0;
  int unsigned     awaited = 0;

  assign mismatch_cnt_o = mismatches;
  assign awaited_cnt_o  = awaited;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic apply_calibration(input logic ok, input logic [95:0] raw);
    int unsigned target;
    int unsigned count;
    longint      quot;
    int          i;
    target = (run_len == '0) ? 1 : int'(run_len);
    if (ok) begin
      for (i = 0; i < NumAxes; i++) begin
        axis_sum[i] = axis_sum[i] + {{(SumW-AxisW){raw[i*AxisW+AxisW-1]}},
                                     raw[i*AxisW +: AxisW]};
      end
    end
    count = seen_cnt + 1;
    if (count >= target) begin
      for (i = 0; i < NumAxes; i++) begin
        quot = longint'(signed'(axis_sum[i])) / longint'(count);
        if (i == AccelZLane) begin
          quot = quot - longint'(gravity);
        end
        axis_bias[i] = quot[AxisW-1:0];
        axis_sum[i]  = '0;
      end
      seen_cnt   = '0;
      calibrated = 1'b1;
    end else begin
      seen_cnt = count[CntW-1:0];
    end
  endtask

  function automatic corrected_t correct_sample(input logic [95:0] raw);
    corrected_t res;
    for (int i = 0; i < NumAxes; i++) begin
      res.axes[i*AxisW +: AxisW] = raw[i*AxisW +: AxisW] - axis_bias[i];
    end
    res.calibrated = calibrated;
    return res;
  endfunction

  always @(posedge clk_i) begin
    corrected_t got;
    corrected_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        axis_sum[i]  = '0;
        axis_bias[i] = '0;
      end
      seen_cnt   = '0;
      calibrated = 1'b0;
      run_len    = SampleCountRst;
      gravity    = GravityRst;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSampleCount:  run_len = cfg_data_i;
          CfgGravityCount: gravity = cfg_data_i[GravW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.axes       = m_axis_tdata;
        got.calibrated = m_axis_tuser;
        if (corrected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h flag %b",
                                    got.axes, got.calibrated));
        end else begin
          want = corrected_q.pop_front();
          for (int i = 0; i < NumAxes; i++) begin
            if (got.axes[i*AxisW +: AxisW] !== want.axes[i*AxisW +: AxisW]) begin
              report_mismatch($sformatf("corrected %s: expected %h, got %h",
                                        axis_label[i], want.axes[i*AxisW +: AxisW],
                                        got.axes[i*AxisW +: AxisW]));
            end
          end
          if (got.calibrated !== want.calibrated) begin
            report_mismatch($sformatf("offsets_valid: expected %b, got %b",
                                      want.calibrated, got.calibrated));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == KindCalib) begin
          apply_calibration(s_axis_tuser[1], s_axis_tdata);
        end else begin
          corrected_q.push_back(correct_sample(s_axis_tdata));
        end
      end
    end
    awaited = corrected_q.size();
  end

endmodule

// ----- verif/imu_offset_calibrate_correct_test.sv -----
// Testbench top that drives IMU samples and register writes and reports the verdict.
module imu_offset_calibrate_correct_test;
  timeunit 1ns;
  timeprecision 1ps;
  import imu_oc_pkg::*;

  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned HoldBurst   = 30;
  localparam int unsigned EndLimit    = 5000;
  localparam logic [CfgIdxW-1:0] UnusedCfgIdx = CfgIdxW'(8'hFE);

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [95:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int unsigned         mismatch_cnt;
  int unsigned         awaited_cnt;

  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         hold_ticket    = 0;
  logic [AxisW-1:0]    axis_base [NumAxes];

  always #5 clk_i = ~clk_i;

  imu_offset_calibrate_correct u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  imu_offset_calibrate_correct_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatch_cnt_o(mismatch_cnt),
    .awaited_cnt_o (awaited_cnt)
  );

  task automatic push_sample(input logic kind, input logic ok, input logic [95:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {$urandom, $urandom, $urandom};
      s_axis_tuser  = 2'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = frame;
    s_axis_tuser  = {ok, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b1;
    cfg_index_i   = idx;
    cfg_data_i    = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (awaited_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [AxisW-1:0] pick_axis(input logic [AxisW-1:0] base);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4, 5: return AxisW'($urandom);
      default: return base + AxisW'($urandom_range(64)) - AxisW'(32);
    endcase
  endfunction

  function automatic logic [95:0] pick_frame();
    logic [95:0] frame;
    for (int i = 0; i < NumAxes; i++) begin
      frame[i*AxisW +: AxisW] = pick_axis(axis_base[i]);
    end
    return frame;
  endfunction

  function automatic logic [CfgDataW-1:0] phase_run_len(input int ph);
    case (ph)
      0: return 16'd1;
      1: return 16'd3;
      2: return 16'd0;
      3: return 16'd7;
      4: return 16'd2;
      5: return 16'd16;
      default: return CfgDataW'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] phase_gravity(input int ph);
    case (ph)
      0: return 16'd0;
      1: return 16'd32767;
      2: return 16'd16384;
      3: return 16'd1;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      run_target;
    int unsigned      burst;
    int unsigned      wait_cycles;
    bit               pressed;
    logic [CfgDataW-1:0] run_len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    for (int i = 0; i < NumAxes; i++) axis_base[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Corrections before any calibration run, failed reads among them.
    push_sample(KindCorrect, 1'b1, {6{16'h8000}});
    push_sample(KindCorrect, 1'b0, {6{16'h7FFF}});
    push_sample(KindCorrect, 1'b0, {3{16'hFFFF, 16'h0000}});

    // A zero sample count ends a run on every calibration request.
    settle();
    write_register(CfgSampleCount, 16'd0);
    write_register(CfgGravityCount, 16'd0);
    push_sample(KindCalib, 1'b1, {6{16'h7FFF}});
    push_sample(KindCorrect, 1'b1, {6{16'h8000}});
    settle();
    write_register(CfgGravityCount, 16'hFFFF);
    push_sample(KindCalib, 1'b1, {6{16'h8000}});
    push_sample(KindCorrect, 1'b0, {6{16'h7FFF}});

    // Negative averages truncate toward zero; a failed read still counts.
    settle();
    write_register(CfgSampleCount, 16'd3);
    write_register(CfgGravityCount, 16'd16384);
    push_sample(KindCalib, 1'b1, {6{16'hFFFB}});
    push_sample(KindCalib, 1'b0, {6{16'h7FFF}});
    push_sample(KindCalib, 1'b1, {6{16'hFFFB}});
    push_sample(KindCorrect, 1'b1, {16'h1234, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001});

    // Lowering the sample count mid-run ends it on the next calibration request.
    settle();
    write_register(CfgSampleCount, 16'hFFFF);
    push_sample(KindCalib, 1'b1, {6{16'h7FFF}});
    push_sample(KindCalib, 1'b1, {6{16'h7FFF}});
    push_sample(KindCalib, 1'b1, {6{16'h8000}});
    push_sample(KindCalib, 1'b1, {16'h0005, 16'hFFF0, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF});
    settle();
    write_register(CfgSampleCount, 16'd2);
    push_sample(KindCalib, 1'b1, {16'h0003, 16'h0010, 16'h0002, 16'h0007, 16'hFFFE, 16'h0001});
    push_sample(KindCorrect, 1'b1, {6{16'h0000}});

    // A write to an index with no register behind it changes nothing.
    settle();
    write_register(UnusedCfgIdx, 16'hFFFF);
    push_sample(KindCorrect, 1'b1, {6{16'h5A5A}});

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      run_len = phase_run_len(ph);
      write_register(CfgSampleCount, run_len);
      write_register(CfgGravityCount, phase_gravity(ph));
      run_target = (run_len == '0) ? 1 : int'(run_len);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      sent    = 0;
      pressed = 1'b0;
      while (sent < PhaseItems) begin
        if (!pressed && sent >= PhaseItems / 2) begin
          pressed = 1'b1;
          hold_ticket++;
          repeat (HoldBurst) push_sample(KindCorrect, 1'($urandom), pick_frame());
          sent += HoldBurst;
          s_axis_tvalid = 1'b0;
          while (awaited_cnt != 0) @(negedge clk_i);
        end
        for (int i = 0; i < NumAxes; i++) axis_base[i] = AxisW'($urandom);
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            for (int k = 0; k < run_target; k++) begin
              push_sample(KindCalib, $urandom_range(9) != 0, pick_frame());
            end
            burst = $urandom_range(1, 3);
            repeat (burst) push_sample(KindCorrect, 1'($urandom), pick_frame());
            sent += run_target + burst;
          end
          11, 12, 13, 14, 15, 16: begin
            burst = $urandom_range(1, 5);
            repeat (burst) push_sample(KindCorrect, 1'($urandom), pick_frame());
            sent += burst;
          end
          default: begin
            push_sample(1'($urandom), 1'($urandom), {$urandom, $urandom, $urandom});
            sent++;
          end
        endcase
      end
    end

    s_axis_tvalid = 1'b0;
    wait_cycles = 0;
    while (awaited_cnt != 0 && wait_cycles < EndLimit) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_cnt == 0 && awaited_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/imu_oc_pkg.sv
hw/rtl/imu_oc_div.sv
hw/rtl/imu_oc_lane.sv
hw/rtl/imu_offset_calibrate_correct.sv
verif/imu_offset_calibrate_correct_checker.sv
verif/imu_offset_calibrate_correct_test.sv
